// ===== hw/rtl/energy_vad_with_hangover_core_defines.svh =====
// ----------------------------------------------------------------------------
// Energy VAD assertion macros
// Shared property macros for the VAD core checks.
// ----------------------------------------------------------------------------
`ifndef ENERGY_VAD_WITH_HANGOVER_CORE_DEFINES_SVH
`define ENERGY_VAD_WITH_HANGOVER_CORE_DEFINES_SVH

// same-cycle implication
`define EVH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EVH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/evh_pkg.sv =====
// ----------------------------------------------------------------------------
// evh_pkg
// Types and register indexes for the energy VAD core.
// ----------------------------------------------------------------------------
package evh_pkg;

  localparam logic [2:0] REG_MIN_FLOOR     = 3'd0;
  localparam logic [2:0] REG_ON_FACTOR     = 3'd1;
  localparam logic [2:0] REG_OFF_FACTOR    = 3'd2;
  localparam logic [2:0] REG_ONSET_FRAMES  = 3'd3;
  localparam logic [2:0] REG_HANGOVER_TIME = 3'd4;
  localparam logic [2:0] REG_FALL_RATE     = 3'd5;
  localparam logic [2:0] REG_RISE_RATE     = 3'd6;

  typedef struct packed {
    logic [15:0] level_in;
    logic [7:0]  frame_time;
  } in_item_t;

  typedef struct packed {
    logic [15:0] level_out;
    logic [15:0] floor_out;
    logic [15:0] snr_ratio;
    logic        speech_active;
    logic        speech_onset;
  } out_item_t;

  typedef struct packed {
    logic [15:0] min_floor;
    logic [11:0] on_factor;
    logic [11:0] off_factor;
    logic [7:0]  onset_frames;
    logic [15:0] hangover_time;
    logic [15:0] fall_rate;
    logic [15:0] rise_rate;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul_on;
    logic mul_off;
    logic mul_step;
    logic cmp_on;
    logic cmp_off;
    logic div_init;
    logic div_step;
    logic decide;
    logic floor_upd;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_sts_t;

endpackage

// ===== hw/rtl/evh_regs.sv =====
// ----------------------------------------------------------------------------
// evh_regs
// Configuration register file, written through the cfg channel.
// ----------------------------------------------------------------------------
module evh_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_wdata,
  output evh_pkg::cfg_t cfg
);
  import evh_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_floor     <= 16'd0;
      cfg_r.on_factor     <= 12'd768;
      cfg_r.off_factor    <= 12'd512;
      cfg_r.onset_frames  <= 8'd2;
      cfg_r.hangover_time <= 16'd300;
      cfg_r.fall_rate     <= 16'd6554;
      cfg_r.rise_rate     <= 16'd655;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_FLOOR:     cfg_r.min_floor     <= cfg_wdata;
        REG_ON_FACTOR:     cfg_r.on_factor     <= cfg_wdata[11:0];
        REG_OFF_FACTOR:    cfg_r.off_factor    <= cfg_wdata[11:0];
        REG_ONSET_FRAMES:  cfg_r.onset_frames  <= cfg_wdata[7:0];
        REG_HANGOVER_TIME: cfg_r.hangover_time <= cfg_wdata;
        REG_FALL_RATE:     cfg_r.fall_rate     <= cfg_wdata;
        REG_RISE_RATE:     cfg_r.rise_rate     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/evh_ctrl.sv =====
// ----------------------------------------------------------------------------
// evh_ctrl
// Sequencer: issues datapath commands per frame and owns the in and out handshakes.
// ----------------------------------------------------------------------------
module evh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output evh_pkg::dp_cmd_t cmd,
  input  evh_pkg::dp_sts_t sts
);
  import evh_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MON  = 3'd1;
  localparam logic [2:0] S_MOFF = 3'd2;
  localparam logic [2:0] S_COFF = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_DEC  = 3'd5;
  localparam logic [2:0] S_UPD  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MON;
        end
      end
      S_MON: begin
        cmd.mul_on   = 1'b1;
        cmd.div_init = 1'b1;
        state_nxt    = S_MOFF;
      end
      S_MOFF: begin
        cmd.cmp_on   = 1'b1;
        cmd.mul_off  = 1'b1;
        cmd.div_step = 1'b1;
        state_nxt    = S_COFF;
      end
      S_COFF: begin
        cmd.cmp_off  = 1'b1;
        cmd.div_step = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.decide   = 1'b1;
        cmd.mul_step = 1'b1;
        state_nxt    = S_UPD;
      end
      S_UPD: begin
        cmd.floor_upd = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/evh_dp.sv =====
// ----------------------------------------------------------------------------
// evh_dp
// Datapath: floor state, shared multiplier, serial divider, speech logic.
// ----------------------------------------------------------------------------
module evh_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  evh_pkg::in_item_t   in_data,
  input  evh_pkg::cfg_t       cfg,
  input  evh_pkg::dp_cmd_t    cmd,
  output evh_pkg::dp_sts_t    sts,
  output evh_pkg::out_item_t  out_data
);
  import evh_pkg::*;

  // model state
  logic [23:0] floor_r;
  logic        seeded_r;
  logic        speech_r;
  logic [15:0] hang_r;
  logic [7:0]  run_r;

  // per-frame working registers
  logic [15:0] level_r;
  logic [7:0]  ftime_r;
  logic [23:0] eff_r;
  logic [39:0] prod_r;
  logic        on_ge_r, off_ge_r;
  logic        below_r, upd_r, onset_r;
  logic [23:0] rem_r;
  logic [31:0] dvd_r;
  logic [4:0]  cnt_r;
  out_item_t   out_r;

  logic [23:0] floor_seed, min_q8, level_q8, diff_w;
  logic [31:0] level_q16;
  logic [15:0] rate_w;
  logic        below_w;
  logic [23:0] mul_a;
  logic [15:0] mul_b;
  logic [39:0] mul_p;
  logic [24:0] rem_sh, rem_sub;
  logic        q_bit;
  logic [7:0]  run_inc, need;
  logic        speech_nxt;
  logic [15:0] hang_nxt;
  logic [7:0]  run_nxt;
  logic [15:0] snr_w;

  assign floor_seed = seeded_r ? floor_r : {in_data.level_in, 8'd0};
  assign min_q8     = {cfg.min_floor, 8'd0};
  assign level_q8   = {level_r, 8'd0};
  assign level_q16  = {level_r, 16'd0};
  assign below_w    = level_q8 < floor_r;
  assign diff_w     = below_w ? (floor_r - level_q8) : (level_q8 - floor_r);
  assign rate_w     = below_w ? cfg.fall_rate : cfg.rise_rate;

  assign mul_a = cmd.mul_step ? diff_w : eff_r;
  assign mul_b = cmd.mul_on  ? {4'd0, cfg.on_factor}  :
                 cmd.mul_off ? {4'd0, cfg.off_factor} : rate_w;
  assign mul_p = {16'd0, mul_a} * {24'd0, mul_b};

  assign rem_sh  = {rem_r, dvd_r[31]};
  assign q_bit   = rem_sh >= {1'b0, eff_r};
  assign rem_sub = rem_sh - {1'b0, eff_r};
  assign sts.div_last = (cnt_r == 5'd31);

  assign run_inc = (run_r != 8'hFF) ? run_r + 8'd1 : run_r;
  assign need    = (cfg.onset_frames == 8'd0) ? 8'd1 : cfg.onset_frames;

  always_comb begin
    speech_nxt = speech_r;
    hang_nxt   = hang_r;
    run_nxt    = run_r;
    if (!speech_r) begin
      if (on_ge_r) begin
        run_nxt = run_inc;
        if (run_inc >= need) begin
          speech_nxt = 1'b1;
          hang_nxt   = cfg.hangover_time;
        end
      end else begin
        run_nxt = 8'd0;
      end
    end else begin
      if (off_ge_r) begin
        hang_nxt = cfg.hangover_time;
      end else if (hang_r <= {8'd0, ftime_r}) begin
        speech_nxt = 1'b0;
        hang_nxt   = 16'd0;
        run_nxt    = 8'd0;
      end else begin
        hang_nxt = hang_r - {8'd0, ftime_r};
      end
    end
  end

  assign snr_w = (eff_r == 24'd0)        ? 16'd0     :
                 (dvd_r[31:16] != 16'd0) ? 16'hFFFF  : dvd_r[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r  <= 24'd0;
      seeded_r <= 1'b0;
      speech_r <= 1'b0;
      hang_r   <= 16'd0;
      run_r    <= 8'd0;
    end else begin
      if (cmd.load) begin
        floor_r  <= floor_seed;
        seeded_r <= 1'b1;
      end
      if (cmd.decide) begin
        speech_r <= speech_nxt;
        hang_r   <= hang_nxt;
        run_r    <= run_nxt;
      end
      if (cmd.floor_upd && upd_r) begin
        floor_r <= below_r ? (floor_r - prod_r[39:16]) : (floor_r + prod_r[39:16]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      level_r <= in_data.level_in;
      ftime_r <= in_data.frame_time;
      eff_r   <= (floor_seed < min_q8) ? min_q8 : floor_seed;
    end
    if (cmd.mul_on || cmd.mul_off || cmd.mul_step) prod_r <= mul_p;
    if (cmd.cmp_on)  on_ge_r  <= {8'd0, level_q16} >= prod_r;
    if (cmd.cmp_off) off_ge_r <= {8'd0, level_q16} >= prod_r;
    if (cmd.div_init) begin
      rem_r <= 24'd0;
      dvd_r <= level_q16;
      cnt_r <= 5'd0;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? rem_sub[23:0] : rem_sh[23:0];
      dvd_r <= {dvd_r[30:0], q_bit};
      cnt_r <= cnt_r + 5'd1;
    end
    if (cmd.decide) begin
      below_r <= below_w;
      upd_r   <= !speech_nxt && !on_ge_r;
      onset_r <= speech_nxt && !speech_r;
    end
    if (cmd.out_load) begin
      out_r.level_out     <= level_r;
      out_r.floor_out     <= eff_r[23:8];
      out_r.snr_ratio     <= snr_w;
      out_r.speech_active <= speech_r;
      out_r.speech_onset  <= onset_r;
    end
  end

  assign out_data = out_r;

endmodule

// ===== hw/rtl/energy_vad_with_hangover_core.sv =====
// ----------------------------------------------------------------------------
// energy_vad_with_hangover_core
// Energy-threshold voice activity detector with onset run and hangover.
//
//   channel | ports                          | request
//   --------+--------------------------------+---------------------------
//   in      | in_valid, in_stall, in_data    | one frame: level, time
//   out     | out_valid, out_stall, out_data | one result per frame
//   cfg     | cfg_valid, cfg_ready, cfg_*    | register index + data
//
// A request is taken only in idle; its result is then produced in order by a
// setup state with the onset multiply, 32 restoring divider steps for the SNR
// (the sustain multiply and both compares share the first two), a decision
// state with the floor step multiply, a floor update and the output load.
// The next request is taken only once the output load has returned to idle.
// A stalled result holds the sequencer in its last state.
// Synchronous reset restores register defaults and clears the model state,
// the sequencer state and the output valid.
module energy_vad_with_hangover_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  evh_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output evh_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import evh_pkg::*;
  `include "energy_vad_with_hangover_core_defines.svh"

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  evh_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  evh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  evh_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg      (cfg),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  `EVH_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "not busy after accept")
  `EVH_ASSERT_NOW(a_onset_in_speech, clk, rst_n, out_valid && out_data.speech_onset, out_data.speech_active, "onset without speech")
  `EVH_ASSERT_NOW(a_zero_level_snr, clk, rst_n, out_valid && (out_data.level_out == 16'd0), out_data.snr_ratio == 16'd0, "nonzero snr for zero level")
  `EVH_ASSERT_NEXT(a_load_once, clk, rst_n, cmd.out_load, !cmd.out_load, "double result load")

endmodule
